FILE: sv/mfdr_pkg.sv
// ============================================================================
// mfdr_pkg
// Shared constants, codes and types of the message queue with descriptor ring.
// ============================================================================
package mfdr_pkg;

    // Storage dimensions.
    localparam int STORE_DEPTH = 4096;
    localparam int RING_DEPTH  = 32;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SLOT_W      = $clog2(RING_DEPTH);
    localparam int RCNT_W      = $clog2(RING_DEPTH + 1);
    localparam int CMDQ_DEPTH  = 2;

    // Field widths.
    localparam int REQ_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int SIZE_W    = 13;
    localparam int OFF_W     = 12;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int RING_CFG_W = 6;

    // Request type codes.
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DROP  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COUNT = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_ENTRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE    = 2'd2;

    // Configuration reset values.
    localparam logic [SIZE_W-1:0]     STORE_BYTES_RST  = 13'd4096;
    localparam logic [RING_CFG_W-1:0] RING_ENTRIES_RST = 6'd32;

    // Request kinds after decoding; count and unknown requests only report.
    typedef enum logic [2:0] {
        K_WRITE,
        K_READ,
        K_DROP,
        K_CLEAR,
        K_REPORT
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              first;
        logic [BYTE_W-1:0] data;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  boff;
    } t_cmd;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   rbyte;
        logic [SIZE_W-1:0]   head_size;
        logic [COUNT_W-1:0]  count;
    } t_result;

endpackage

FILE: sv/message_fifo_with_descriptor_ring.sv
// ============================================================================
// message_fifo_with_descriptor_ring
// Queue of variable-length messages kept contiguous in a byte store.
// ============================================================================
// A request is taken at a rising edge with start high and busy low. A write
// request carries one message byte; byte 0 decides placement and the final
// byte commits the descriptor. Read, drop, clear and count requests act on
// the head message or the queue as a whole. Every request gives exactly one
// result, shown for one cycle with o_result_valid high; the receiver cannot
// stall, so results are never held back.
// Requests pass through a two-entry command queue, so busy rises only when
// that queue is full. The sequencer takes clear and count from its execute
// state to its done state. A read adds a state for the registered byte store
// read, a write byte a state for the store write, and byte 0 a placement
// state before it. A drop adds a request and a data state for the registered
// head descriptor read, which byte 0 also makes to drop the oldest message.
// Configuration writes take effect at once and are meant for idle periods;
// a new store or ring size empties the queue. Synchronous reset empties the
// queue and restores the default sizes; stored data is not cleared.
// ============================================================================
module message_fifo_with_descriptor_ring (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [mfdr_pkg::REQ_W-1:0]        i_req_type,
    input  logic [mfdr_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic [mfdr_pkg::SIZE_W-1:0]       i_msg_size,
    input  logic [mfdr_pkg::OFF_W-1:0]        i_byte_offset,
    output logic                              o_result_valid,
    output logic [mfdr_pkg::STATUS_W-1:0]     o_status,
    output logic [mfdr_pkg::BYTE_W-1:0]       o_read_byte,
    output logic [mfdr_pkg::SIZE_W-1:0]       o_head_size,
    output logic [mfdr_pkg::COUNT_W-1:0]      o_message_count,
    input  logic                              i_cfg_we,
    input  logic [mfdr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfdr_pkg::CFG_W-1:0]        i_cfg_data
);

    logic              w_push;
    logic              w_pop;
    logic              w_q_valid;
    logic              w_q_full;
    mfdr_pkg::t_cmd    w_front_cmd;
    mfdr_pkg::t_cmd    w_q_cmd;
    mfdr_pkg::t_result w_result;

    mfdr_front u_front (
        .i_start       (start),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .i_msg_size    (i_msg_size),
        .i_byte_offset (i_byte_offset),
        .i_q_full      (w_q_full),
        .o_busy        (busy),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    mfdr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_cmd   (w_q_cmd)
    );

    mfdr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_pop),
        .o_result    (w_result)
    );

    assign o_result_valid  = w_result.valid;
    assign o_status        = w_result.status;
    assign o_read_byte     = w_result.rbyte;
    assign o_head_size     = w_result.head_size;
    assign o_message_count = w_result.count;

endmodule

FILE: sv/mfdr_ram.sv
// ============================================================================
// mfdr_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module mfdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/mfdr_front.sv
// ============================================================================
// mfdr_front
// Request front end: accepts requests and decodes them into queue commands.
// ============================================================================
module mfdr_front (
    input  logic                          i_start,
    input  logic [mfdr_pkg::REQ_W-1:0]    i_req_type,
    input  logic [mfdr_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [mfdr_pkg::SIZE_W-1:0]   i_msg_size,
    input  logic [mfdr_pkg::OFF_W-1:0]    i_byte_offset,
    input  logic                          i_q_full,
    output logic                          o_busy,
    output logic                          o_push,
    output mfdr_pkg::t_cmd                o_cmd
);

    mfdr_pkg::t_kind w_kind;

    always_comb begin
        unique case (i_req_type)
            mfdr_pkg::REQ_WRITE: w_kind = mfdr_pkg::K_WRITE;
            mfdr_pkg::REQ_READ:  w_kind = mfdr_pkg::K_READ;
            mfdr_pkg::REQ_DROP:  w_kind = mfdr_pkg::K_DROP;
            mfdr_pkg::REQ_CLEAR: w_kind = mfdr_pkg::K_CLEAR;
            mfdr_pkg::REQ_COUNT: w_kind = mfdr_pkg::K_REPORT;
            default:             w_kind = mfdr_pkg::K_REPORT;
        endcase
    end

    assign o_busy       = i_q_full;
    assign o_push       = i_start && !i_q_full;
    assign o_cmd.kind   = w_kind;
    assign o_cmd.first  = (i_byte_offset == '0);
    assign o_cmd.data   = i_data_byte;
    assign o_cmd.size   = i_msg_size;
    assign o_cmd.boff   = i_byte_offset;

endmodule

FILE: sv/mfdr_cmdq.sv
// ============================================================================
// mfdr_cmdq
// Short command queue between the front end and the execution sequencer.
// ============================================================================
module mfdr_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mfdr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output mfdr_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (mfdr_pkg::CMDQ_DEPTH > 1) ? $clog2(mfdr_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(mfdr_pkg::CMDQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mfdr_pkg::CMDQ_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(mfdr_pkg::CMDQ_DEPTH);

    mfdr_pkg::t_cmd   r_mem [mfdr_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_cmd   = r_mem[r_rp];

endmodule

FILE: sv/mfdr_back.sv
// ============================================================================
// mfdr_back
// Execution sequencer: placement, byte store and descriptor ring upkeep.
// ============================================================================
module mfdr_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mfdr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mfdr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_q_valid,
    input  mfdr_pkg::t_cmd                   i_q_cmd,
    output logic                             o_q_pop,
    output mfdr_pkg::t_result                o_result
);

    localparam int SW  = mfdr_pkg::SIZE_W;
    localparam int OW  = mfdr_pkg::OFF_W;
    localparam int SLW = mfdr_pkg::SLOT_W;
    localparam int RW  = mfdr_pkg::RCNT_W;
    localparam int DW  = OW + SW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HREQ,
        S_HDAT,
        S_PLACE,
        S_WBYTE,
        S_RDAT,
        S_DONE
    } t_state;

    function automatic logic [SW-1:0] store_clamp(input logic [SW-1:0] v);
        logic [SW-1:0] res;
        if (v == '0) begin
            res = SW'(1);
        end else if (32'(v) > mfdr_pkg::STORE_DEPTH) begin
            res = SW'(mfdr_pkg::STORE_DEPTH);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [RW-1:0] ring_clamp(input logic [mfdr_pkg::RING_CFG_W-1:0] v);
        logic [RW-1:0] res;
        if (32'(v) < 2) begin
            res = RW'(2);
        end else if (32'(v) > mfdr_pkg::RING_DEPTH) begin
            res = RW'(mfdr_pkg::RING_DEPTH);
        end else begin
            res = RW'(v);
        end
        return res;
    endfunction

    function automatic logic [SLW-1:0] next_slot(input logic [SLW-1:0] s,
                                                 input logic [RW-1:0] r);
        logic [RW:0] t;
        t = (RW + 1)'(s) + (RW + 1)'(1);
        return (t >= (RW + 1)'(r)) ? '0 : SLW'(t);
    endfunction

    t_state                         r_state;
    t_state                         r_after;
    mfdr_pkg::t_cmd                 r_cmd;
    logic [SLW-1:0]                 r_newest;
    logic [SLW-1:0]                 r_oldest;
    logic                           r_pend_acc;
    logic [OW-1:0]                  r_pend_off;
    logic [SW-1:0]                  r_pend_size;
    logic [SW-1:0]                  r_newest_end;
    logic [OW-1:0]                  r_head_off;
    logic [SW-1:0]                  r_head_size;
    logic [SW-1:0]                  r_cap;
    logic [RW-1:0]                  r_ring;
    logic                           r_ovw;
    logic [mfdr_pkg::STATUS_W-1:0]  r_status;
    logic [mfdr_pkg::BYTE_W-1:0]    r_rbyte;
    mfdr_pkg::t_result              r_res;

    logic                           w_empty;
    logic                           w_full;
    logic [RW-1:0]                  w_count;
    logic                           p_acc;
    logic [OW-1:0]                  p_off;
    logic [SW-1:0]                  w_of;
    logic [SW-1:0]                  w_ol;
    logic [SW-1:0]                  w_widx;
    logic [SW-1:0]                  w_ridx;
    logic                           w_wr_ok;
    logic                           w_last;
    logic                           w_rd_in;
    logic                           st_we;
    logic                           st_re;
    logic [mfdr_pkg::BYTE_W-1:0]    st_q;
    logic                           d_we;
    logic                           d_re;
    logic [DW-1:0]                  d_q;

    assign w_empty = (r_newest == r_oldest);
    assign w_full  = (next_slot(r_newest, r_ring) == r_oldest);
    assign w_count = (r_newest >= r_oldest) ? RW'(r_newest) - RW'(r_oldest)
                                            : r_ring - RW'(r_oldest) + RW'(r_newest);

    // Placement of a new message against the newest end and the oldest offset.
    assign w_of = r_newest_end;
    assign w_ol = SW'(r_head_off);

    always_comb begin
        p_acc = 1'b0;
        p_off = '0;
        if (r_cmd.size == '0) begin
            p_acc = 1'b0;
        end else if (w_empty) begin
            p_acc = (r_cmd.size <= r_cap);
        end else if (w_of > w_ol) begin
            if (w_of <= r_cap && (r_cap - w_of) >= r_cmd.size) begin
                p_acc = 1'b1;
                p_off = OW'(w_of);
            end else if (w_ol > r_cmd.size) begin
                p_acc = 1'b1;
            end
        end else if ((w_ol - w_of) > r_cmd.size) begin
            p_acc = 1'b1;
            p_off = OW'(w_of);
        end
    end

    assign w_widx  = SW'(r_pend_off) + SW'(r_cmd.boff);
    assign w_wr_ok = r_pend_acc && (SW'(r_cmd.boff) < r_pend_size);
    assign w_last  = (SW'(r_cmd.boff) + SW'(1)) == r_pend_size;
    assign w_ridx  = SW'(r_head_off) + SW'(r_cmd.boff);
    assign w_rd_in = (32'(w_ridx) < mfdr_pkg::STORE_DEPTH);

    assign st_we = (r_state == S_WBYTE) && w_wr_ok && (32'(w_widx) < mfdr_pkg::STORE_DEPTH);
    assign st_re = (r_state == S_EXEC) && (r_cmd.kind == mfdr_pkg::K_READ) && !w_empty
                   && (SW'(r_cmd.boff) < r_head_size) && w_rd_in;
    assign d_we  = (r_state == S_WBYTE) && w_wr_ok && w_last;
    assign d_re  = (r_state == S_HREQ);

    assign o_q_pop = ((r_state == S_IDLE) || (r_state == S_DONE)) && i_q_valid;

    mfdr_ram #(
        .WIDTH (mfdr_pkg::BYTE_W),
        .DEPTH (mfdr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (mfdr_pkg::STORE_AW'(w_widx)),
        .i_wdata (r_cmd.data),
        .i_re    (st_re),
        .i_raddr (mfdr_pkg::STORE_AW'(w_ridx)),
        .o_rdata (st_q)
    );

    mfdr_ram #(
        .WIDTH (DW),
        .DEPTH (mfdr_pkg::RING_DEPTH)
    ) u_desc (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_newest),
        .i_wdata ({r_pend_off, r_pend_size}),
        .i_re    (d_re),
        .i_raddr (r_oldest),
        .o_rdata (d_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_DONE;
            r_newest    <= '0;
            r_oldest    <= '0;
            r_pend_acc  <= 1'b0;
            r_pend_off  <= '0;
            r_pend_size <= '0;
            r_cap       <= store_clamp(mfdr_pkg::STORE_BYTES_RST);
            r_ring      <= ring_clamp(mfdr_pkg::RING_ENTRIES_RST);
            r_ovw       <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= mfdr_pkg::ST_OK;
                    r_rbyte  <= '0;
                    r_state  <= S_DONE;
                    unique case (r_cmd.kind)
                        mfdr_pkg::K_WRITE: begin
                            if (!r_cmd.first) begin
                                r_state <= S_WBYTE;
                            end else if (!w_full) begin
                                r_state <= S_PLACE;
                            end else if (r_ovw) begin
                                // Drop the oldest message, then refresh the head cache.
                                r_oldest <= next_slot(r_oldest, r_ring);
                                r_after  <= S_PLACE;
                                r_state  <= S_HREQ;
                            end else begin
                                r_pend_acc  <= 1'b0;
                                r_pend_size <= '0;
                                r_status    <= mfdr_pkg::ST_REJECT;
                            end
                        end
                        mfdr_pkg::K_READ: begin
                            if (w_empty) begin
                                r_status <= mfdr_pkg::ST_EMPTY;
                            end else if (SW'(r_cmd.boff) >= r_head_size) begin
                                r_status <= mfdr_pkg::ST_REJECT;
                            end else if (w_rd_in) begin
                                r_state <= S_RDAT;
                            end
                        end
                        mfdr_pkg::K_DROP: begin
                            if (w_empty) begin
                                r_status <= mfdr_pkg::ST_EMPTY;
                            end else begin
                                r_oldest <= next_slot(r_oldest, r_ring);
                                r_after  <= S_DONE;
                                r_state  <= S_HREQ;
                            end
                        end
                        mfdr_pkg::K_CLEAR: begin
                            r_newest    <= '0;
                            r_oldest    <= '0;
                            r_pend_acc  <= 1'b0;
                            r_pend_off  <= '0;
                            r_pend_size <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_HREQ: begin
                    r_state <= S_HDAT;
                end
                S_HDAT: begin
                    r_head_off  <= d_q[SW +: OW];
                    r_head_size <= d_q[SW-1:0];
                    r_state     <= r_after;
                end
                S_PLACE: begin
                    if (w_empty && r_cmd.size != '0) begin
                        r_newest <= '0;
                        r_oldest <= '0;
                    end
                    r_pend_acc  <= p_acc;
                    r_pend_size <= p_acc ? r_cmd.size : '0;
                    if (p_acc) begin
                        r_pend_off <= p_off;
                        r_state    <= S_WBYTE;
                    end else begin
                        r_status <= mfdr_pkg::ST_REJECT;
                        r_state  <= S_DONE;
                    end
                end
                S_WBYTE: begin
                    r_state <= S_DONE;
                    if (!w_wr_ok) begin
                        r_status <= mfdr_pkg::ST_REJECT;
                    end else if (w_last) begin
                        // A message committed into an empty ring becomes the head.
                        if (w_empty) begin
                            r_head_off  <= r_pend_off;
                            r_head_size <= r_pend_size;
                        end
                        r_newest_end <= SW'(r_pend_off) + r_pend_size;
                        r_newest     <= next_slot(r_newest, r_ring);
                        r_pend_acc   <= 1'b0;
                    end
                end
                S_RDAT: begin
                    r_rbyte <= st_q;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_res.valid     <= 1'b1;
                    r_res.status    <= r_status;
                    r_res.rbyte     <= r_rbyte;
                    r_res.head_size <= w_empty ? '0 : r_head_size;
                    r_res.count     <= mfdr_pkg::COUNT_W'(w_count);
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= S_EXEC;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Register writes must arrive only while idle; nothing here enforces it.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mfdr_pkg::CFG_STORE_BYTES: begin
                        r_cap       <= store_clamp(SW'(i_cfg_data));
                        r_newest    <= '0;
                        r_oldest    <= '0;
                        r_pend_acc  <= 1'b0;
                        r_pend_off  <= '0;
                        r_pend_size <= '0;
                    end
                    mfdr_pkg::CFG_RING_ENTRIES: begin
                        r_ring      <= ring_clamp(i_cfg_data[mfdr_pkg::RING_CFG_W-1:0]);
                        r_newest    <= '0;
                        r_oldest    <= '0;
                        r_pend_acc  <= 1'b0;
                        r_pend_off  <= '0;
                        r_pend_size <= '0;
                    end
                    mfdr_pkg::CFG_OVERWRITE: begin
                        r_ovw <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_result = r_res;

endmodule

FILE: tb/tb_message_fifo_with_descriptor_ring.sv
// ============================================================================
// tb_message_fifo_with_descriptor_ring
// Self-checking bench for the message queue with descriptor ring. Requests
// are sent with random gaps and every result is compared, field by field,
// with the answer of an untimed copy of the queue kept in a scoreboard class.
// ============================================================================

typedef struct packed {
    logic [mfdr_pkg::STATUS_W-1:0] status;
    logic [mfdr_pkg::BYTE_W-1:0]   rbyte;
    logic [mfdr_pkg::SIZE_W-1:0]   head_size;
    logic [mfdr_pkg::COUNT_W-1:0]  count;
} t_queue_reply;

class msg_queue_board;
    bit [mfdr_pkg::BYTE_W-1:0] byte_mem [mfdr_pkg::STORE_DEPTH];
    bit                        byte_set [mfdr_pkg::STORE_DEPTH];
    bit [mfdr_pkg::OFF_W-1:0]  slot_off [mfdr_pkg::RING_DEPTH];
    bit [mfdr_pkg::SIZE_W-1:0] slot_len [mfdr_pkg::RING_DEPTH];
    int                        newest;
    int                        oldest;
    int                        pend_off;
    int                        pend_len;
    bit                        pend_ok;
    int                        cfg_store;
    int                        cfg_ring;
    bit                        cfg_overwrite;
    int                        errors;
    t_queue_reply              expected_replies [$];

    function new();
        cfg_store     = int'(mfdr_pkg::STORE_BYTES_RST);
        cfg_ring      = int'(mfdr_pkg::RING_ENTRIES_RST);
        cfg_overwrite = 1'b0;
        errors        = 0;
        pend_off      = 0;
        clear_queue();
    endfunction

    function int store_cap();
        if (cfg_store < 1) return 1;
        if (cfg_store > mfdr_pkg::STORE_DEPTH) return mfdr_pkg::STORE_DEPTH;
        return cfg_store;
    endfunction

    function int ring_len();
        if (cfg_ring < 2) return 2;
        if (cfg_ring > mfdr_pkg::RING_DEPTH) return mfdr_pkg::RING_DEPTH;
        return cfg_ring;
    endfunction

    function int next_slot(int s);
        return (s + 1 >= ring_len()) ? 0 : s + 1;
    endfunction

    function int msg_count();
        return (newest >= oldest) ? newest - oldest : ring_len() - oldest + newest;
    endfunction

    function void clear_queue();
        newest   = 0;
        oldest   = 0;
        pend_ok  = 1'b0;
        pend_off = 0;
        pend_len = 0;
    endfunction

    function int outstanding();
        return expected_replies.size();
    endfunction

    function bit is_empty();
        return newest == oldest;
    endfunction

    function int head_len();
        return int'(slot_len[oldest]);
    endfunction

    // Byte 0 of a stored message is always written; later bytes may be holes.
    function bit head_byte_known(int boff);
        return byte_set[int'(slot_off[oldest]) + boff];
    endfunction

    // Decides where a new message of sz bytes goes; 1 when it has room.
    function bit place(int sz);
        int cap;
        int prev;
        int free_at;
        int head_at;
        cap = store_cap();
        if (next_slot(newest) == oldest) begin
            if (!cfg_overwrite) return 1'b0;
            oldest = next_slot(oldest);
        end
        if (sz == 0) return 1'b0;
        if (newest == oldest) begin
            newest = 0;
            oldest = 0;
            if (sz > cap) return 1'b0;
            pend_off = 0;
            return 1'b1;
        end
        prev    = (newest == 0) ? ring_len() - 1 : newest - 1;
        free_at = int'(slot_off[prev]) + int'(slot_len[prev]);
        head_at = int'(slot_off[oldest]);
        if (free_at > head_at) begin
            if (free_at <= cap && cap - free_at >= sz) begin
                pend_off = free_at;
                return 1'b1;
            end
            // Wrapping to the start needs room strictly below the oldest message.
            if (head_at > sz) begin
                pend_off = 0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (head_at - free_at > sz) begin
            pend_off = free_at;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void write_cfg(logic [mfdr_pkg::CFG_IDX_W-1:0] idx, int value);
        case (idx)
            mfdr_pkg::CFG_STORE_BYTES: begin
                cfg_store = value & ((1 << mfdr_pkg::SIZE_W) - 1);
                clear_queue();
            end
            mfdr_pkg::CFG_RING_ENTRIES: begin
                cfg_ring = value & ((1 << mfdr_pkg::RING_CFG_W) - 1);
                clear_queue();
            end
            mfdr_pkg::CFG_OVERWRITE: cfg_overwrite = value[0];
            default: ;
        endcase
    endfunction

    function void note_request(logic [mfdr_pkg::REQ_W-1:0] req,
                               logic [mfdr_pkg::BYTE_W-1:0] data,
                               logic [mfdr_pkg::SIZE_W-1:0] size,
                               logic [mfdr_pkg::OFF_W-1:0] boff);
        t_queue_reply r;
        bit           was_empty;
        int           idx;
        r         = '0;
        was_empty = (newest == oldest);
        case (req)
            mfdr_pkg::REQ_WRITE: begin
                if (boff == 0) begin
                    pend_ok  = place(int'(size));
                    pend_len = pend_ok ? int'(size) : 0;
                    if (!pend_ok) r.status = mfdr_pkg::ST_REJECT;
                end
                if (r.status == mfdr_pkg::ST_OK) begin
                    if (!pend_ok || int'(boff) >= pend_len) begin
                        r.status = mfdr_pkg::ST_REJECT;
                    end else begin
                        idx = pend_off + int'(boff);
                        if (idx < mfdr_pkg::STORE_DEPTH) begin
                            byte_mem[idx] = data;
                            byte_set[idx] = 1'b1;
                        end
                        if (int'(boff) + 1 == pend_len) begin
                            slot_off[newest] = mfdr_pkg::OFF_W'(pend_off);
                            slot_len[newest] = mfdr_pkg::SIZE_W'(pend_len);
                            newest           = next_slot(newest);
                            pend_ok          = 1'b0;
                        end
                    end
                end
            end
            mfdr_pkg::REQ_READ: begin
                if (was_empty) begin
                    r.status = mfdr_pkg::ST_EMPTY;
                end else if (int'(boff) >= int'(slot_len[oldest])) begin
                    r.status = mfdr_pkg::ST_REJECT;
                end else begin
                    idx = int'(slot_off[oldest]) + int'(boff);
                    if (idx < mfdr_pkg::STORE_DEPTH) r.rbyte = byte_mem[idx];
                end
            end
            mfdr_pkg::REQ_DROP: begin
                if (was_empty) r.status = mfdr_pkg::ST_EMPTY;
                else oldest = next_slot(oldest);
            end
            mfdr_pkg::REQ_CLEAR: clear_queue();
            default: ;
        endcase
        r.head_size = (newest == oldest) ? '0 : slot_len[oldest];
        r.count     = mfdr_pkg::COUNT_W'(msg_count());
        expected_replies.push_back(r);
    endfunction

    function void check_result(t_queue_reply got);
        t_queue_reply want;
        if (expected_replies.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        want = expected_replies.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.rbyte !== want.rbyte) begin
            $error("read_byte: expected %0d, got %0d", want.rbyte, got.rbyte);
            errors++;
        end
        if (got.head_size !== want.head_size) begin
            $error("head_size: expected %0d, got %0d", want.head_size, got.head_size);
            errors++;
        end
        if (got.count !== want.count) begin
            $error("message_count: expected %0d, got %0d", want.count, got.count);
            errors++;
        end
    endfunction
endclass

module tb_message_fifo_with_descriptor_ring;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 106;
    localparam int N_PHASES    = 7;

    // Highest request code; codes above the count request are unknown.
    localparam logic [mfdr_pkg::REQ_W-1:0] REQ_TOP = 3'd7;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [mfdr_pkg::REQ_W-1:0]     i_req_type;
    logic [mfdr_pkg::BYTE_W-1:0]    i_data_byte;
    logic [mfdr_pkg::SIZE_W-1:0]    i_msg_size;
    logic [mfdr_pkg::OFF_W-1:0]     i_byte_offset;
    logic                           o_result_valid;
    logic [mfdr_pkg::STATUS_W-1:0]  o_status;
    logic [mfdr_pkg::BYTE_W-1:0]    o_read_byte;
    logic [mfdr_pkg::SIZE_W-1:0]    o_head_size;
    logic [mfdr_pkg::COUNT_W-1:0]   o_message_count;
    logic                           i_cfg_we;
    logic [mfdr_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mfdr_pkg::CFG_W-1:0]     i_cfg_data;

    msg_queue_board board;
    bit             gapless     = 1'b0;
    int             sent_items  = 0;
    int             stall_count = 0;

    // Store size, ring size and overwrite mode of each random phase after the first.
    int phase_store [N_PHASES] = '{64, 1, 0, 8191, 200, 37, 4096};
    int phase_ring  [N_PHASES] = '{4, 2, 0, 63, 8, 3, 32};
    bit phase_ovw   [N_PHASES] = '{1, 0, 1, 1, 0, 1, 0};

    message_fifo_with_descriptor_ring u_top (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            board.check_result({o_status, o_read_byte, o_head_size, o_message_count});
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && !busy) || o_result_valid) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("FAIL message_fifo_with_descriptor_ring");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic logic [mfdr_pkg::BYTE_W-1:0] rand_byte();
        return mfdr_pkg::BYTE_W'($urandom);
    endfunction

    function automatic logic [mfdr_pkg::SIZE_W-1:0] rand_size();
        return mfdr_pkg::SIZE_W'($urandom);
    endfunction

    function automatic logic [mfdr_pkg::OFF_W-1:0] rand_off();
        return mfdr_pkg::OFF_W'($urandom);
    endfunction

    task automatic send_req(logic [mfdr_pkg::REQ_W-1:0] req,
                            logic [mfdr_pkg::BYTE_W-1:0] data,
                            logic [mfdr_pkg::SIZE_W-1:0] size,
                            logic [mfdr_pkg::OFF_W-1:0] boff);
        int gap;
        gap = gapless ? 0 : int'($urandom_range(0, 8));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= req;
        i_data_byte   <= data;
        i_msg_size    <= size;
        i_byte_offset <= boff;
        do @(posedge i_clk); while (busy);
        board.note_request(req, data, size, boff);
        if (req <= mfdr_pkg::REQ_COUNT) sent_items++;
        if ($urandom_range(0, 39) == 0) gapless = !gapless;
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    task automatic set_config(int store_val, int ring_val, bit ovw);
        drain_replies();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mfdr_pkg::CFG_STORE_BYTES;
        i_cfg_data  <= store_val[mfdr_pkg::CFG_W-1:0];
        @(posedge i_clk);
        board.write_cfg(mfdr_pkg::CFG_STORE_BYTES, store_val);
        i_cfg_index <= mfdr_pkg::CFG_RING_ENTRIES;
        i_cfg_data  <= ring_val[mfdr_pkg::CFG_W-1:0];
        @(posedge i_clk);
        board.write_cfg(mfdr_pkg::CFG_RING_ENTRIES, ring_val);
        i_cfg_index <= mfdr_pkg::CFG_OVERWRITE;
        i_cfg_data  <= mfdr_pkg::CFG_W'(ovw);
        @(posedge i_clk);
        board.write_cfg(mfdr_pkg::CFG_OVERWRITE, int'(ovw));
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly sizes that fit the store in use, a few that cannot fit anywhere.
    function automatic int pick_size();
        int cap;
        int r;
        cap = board.store_cap();
        r   = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, (cap < 16) ? cap : 16);
        if (r < 85) return $urandom_range(1, (cap < 4) ? 1 : cap / 4);
        if (r < 95) return $urandom_range(1, cap);
        if (r < 98) return $urandom_range(cap, mfdr_pkg::STORE_DEPTH);
        return ($urandom_range(0, 1) == 0) ? 0
               : $urandom_range(mfdr_pkg::STORE_DEPTH + 1, 8191);
    endfunction

    // Long messages get byte 0, a few inner bytes and the final byte only.
    task automatic write_message(int size);
        int b;
        send_req(mfdr_pkg::REQ_WRITE, rand_byte(), mfdr_pkg::SIZE_W'(size), '0);
        if (size > 1 && size <= mfdr_pkg::STORE_DEPTH) begin
            if (size <= 12) begin
                for (b = 1; b < size; b++)
                    send_req(mfdr_pkg::REQ_WRITE, rand_byte(), mfdr_pkg::SIZE_W'(size),
                             mfdr_pkg::OFF_W'(b));
            end else begin
                repeat ($urandom_range(0, 4))
                    send_req(mfdr_pkg::REQ_WRITE, rand_byte(), mfdr_pkg::SIZE_W'(size),
                             mfdr_pkg::OFF_W'($urandom_range(1, size - 2)));
                send_req(mfdr_pkg::REQ_WRITE, rand_byte(), mfdr_pkg::SIZE_W'(size),
                         mfdr_pkg::OFF_W'(size - 1));
            end
        end
    endtask

    task automatic write_broken();
        int size;
        size = pick_size();
        case ($urandom_range(0, 2))
            0: begin
                // Left unfinished; the next byte 0 abandons it.
                send_req(mfdr_pkg::REQ_WRITE, rand_byte(), mfdr_pkg::SIZE_W'(size), '0);
                if (size > 2 && size <= mfdr_pkg::STORE_DEPTH)
                    repeat ($urandom_range(1, 3))
                        send_req(mfdr_pkg::REQ_WRITE, rand_byte(), mfdr_pkg::SIZE_W'(size),
                                 mfdr_pkg::OFF_W'($urandom_range(1, size - 2)));
            end
            1: send_req(mfdr_pkg::REQ_WRITE, rand_byte(), rand_size(),
                        mfdr_pkg::OFF_W'($urandom_range(1, mfdr_pkg::STORE_DEPTH - 1)));
            default: begin
                send_req(mfdr_pkg::REQ_WRITE, rand_byte(), mfdr_pkg::SIZE_W'(size), '0);
                if (size < mfdr_pkg::STORE_DEPTH)
                    send_req(mfdr_pkg::REQ_WRITE, rand_byte(), mfdr_pkg::SIZE_W'(size),
                             mfdr_pkg::OFF_W'($urandom_range(size,
                                                             mfdr_pkg::STORE_DEPTH - 1)));
            end
        endcase
    endtask

    // Reads never land on a byte of the head message that was never written.
    task automatic read_head();
        int                         len;
        logic [mfdr_pkg::OFF_W-1:0] boff;
        boff = rand_off();
        if (!board.is_empty()) begin
            len = board.head_len();
            if ($urandom_range(0, 4) != 0)
                boff = mfdr_pkg::OFF_W'($urandom_range(0, len - 1));
            else if (len < mfdr_pkg::STORE_DEPTH)
                boff = mfdr_pkg::OFF_W'($urandom_range(len, mfdr_pkg::STORE_DEPTH - 1));
            if (int'(boff) < len && !board.head_byte_known(int'(boff))) boff = '0;
        end
        send_req(mfdr_pkg::REQ_READ, rand_byte(), rand_size(), boff);
    endtask

    task automatic random_phase();
        int first;
        int pick;
        first = sent_items;
        while (sent_items - first < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      write_message(pick_size());
            else if (pick < 55) write_broken();
            else if (pick < 80) read_head();
            else if (pick < 90)
                send_req(mfdr_pkg::REQ_DROP, rand_byte(), rand_size(), rand_off());
            else if (pick < 93)
                send_req(mfdr_pkg::REQ_CLEAR, rand_byte(), rand_size(), rand_off());
            else if (pick < 97)
                send_req(mfdr_pkg::REQ_COUNT, rand_byte(), rand_size(), rand_off());
            else
                send_req(mfdr_pkg::REQ_W'($urandom_range(32'(mfdr_pkg::REQ_COUNT) + 1,
                                                         32'(REQ_TOP))),
                         rand_byte(), rand_size(), rand_off());
        end
    endtask

    initial begin
        board         = new();
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_req_type    <= mfdr_pkg::REQ_COUNT;
        i_data_byte   <= '0;
        i_msg_size    <= '0;
        i_byte_offset <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= mfdr_pkg::CFG_STORE_BYTES;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue, stray bytes and sizes that cannot be placed.
        send_req(mfdr_pkg::REQ_READ, 8'h00, 13'd0, 12'd0);
        send_req(mfdr_pkg::REQ_DROP, 8'h00, 13'd0, 12'd0);
        send_req(mfdr_pkg::REQ_COUNT, 8'hFF, 13'h1FFF, 12'hFFF);
        send_req(REQ_TOP, 8'hFF, 13'h1FFF, 12'hFFF);
        send_req(mfdr_pkg::REQ_WRITE, 8'h11, 13'd10, 12'd5);
        send_req(mfdr_pkg::REQ_WRITE, 8'h22, 13'd0, 12'd0);
        send_req(mfdr_pkg::REQ_WRITE, 8'h33, 13'h1FFF, 12'd0);
        // A short message, then reads inside and past its end.
        send_req(mfdr_pkg::REQ_WRITE, 8'h00, 13'd3, 12'd0);
        send_req(mfdr_pkg::REQ_WRITE, 8'hFF, 13'd3, 12'd1);
        send_req(mfdr_pkg::REQ_WRITE, 8'hA5, 13'd3, 12'd2);
        send_req(mfdr_pkg::REQ_READ, 8'h00, 13'd0, 12'd0);
        send_req(mfdr_pkg::REQ_READ, 8'h00, 13'd0, 12'd2);
        send_req(mfdr_pkg::REQ_READ, 8'h00, 13'd0, 12'd3);
        send_req(mfdr_pkg::REQ_READ, 8'h00, 13'd0, 12'hFFF);
        // A full-store message no longer fits anywhere.
        send_req(mfdr_pkg::REQ_WRITE, 8'h44, 13'd4096, 12'd0);
        // A fresh byte 0 abandons the unfinished message.
        send_req(mfdr_pkg::REQ_WRITE, 8'h55, 13'd2, 12'd0);
        send_req(mfdr_pkg::REQ_WRITE, 8'h5A, 13'd1, 12'd0);
        send_req(mfdr_pkg::REQ_WRITE, 8'h66, 13'd4, 12'd0);
        send_req(mfdr_pkg::REQ_WRITE, 8'h77, 13'd4, 12'd4);
        send_req(mfdr_pkg::REQ_WRITE, 8'h88, 13'd4, 12'd3);
        send_req(mfdr_pkg::REQ_COUNT, 8'h00, 13'd0, 12'd0);
        send_req(mfdr_pkg::REQ_DROP, 8'h00, 13'd0, 12'd0);
        send_req(mfdr_pkg::REQ_READ, 8'h00, 13'd0, 12'd0);
        send_req(mfdr_pkg::REQ_CLEAR, 8'h00, 13'd0, 12'd0);
        send_req(mfdr_pkg::REQ_COUNT, 8'h00, 13'd0, 12'd0);

        random_phase();
        for (int p = 0; p < N_PHASES; p++) begin
            set_config(phase_store[p], phase_ring[p], phase_ovw[p]);
            random_phase();
        end

        drain_replies();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS message_fifo_with_descriptor_ring");
        end else begin
            $display("FAIL message_fifo_with_descriptor_ring");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/mfdr_pkg.sv
sv/mfdr_ram.sv
sv/mfdr_front.sv
sv/mfdr_cmdq.sv
sv/mfdr_back.sv
sv/message_fifo_with_descriptor_ring.sv
tb/tb_message_fifo_with_descriptor_ring.sv
